### hdl/oce_pkg.sv
// ----------------------------------------------------------------------------
// oce_pkg
// Shared types and constants for the object centroid and extent block.
// ----------------------------------------------------------------------------
package oce_pkg;

    localparam int SCALE_BITS  = 16;
    localparam int SIZE_BITS   = 32;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd256;

    // controller to datapath
    typedef struct packed {
        logic accumulate;   // take the accepted word into sums and corners
        logic finish_load;  // latch dividends, divisor and squared diagonal
        logic div_step;     // one restoring divide step on all axes
        logic sqrt_step;    // one square root step
        logic scale_mul;    // register the scaled size
        logic result_load;  // move the finished result to the output register
        logic clear;        // return accumulators to reset values
    } oce_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
    } oce_status_t;

endpackage

### hdl/oce_stream_if.sv
// ----------------------------------------------------------------------------
// oce_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface oce_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/object_centroid_and_extent.sv
// After an object's last vertex the block loads, runs 41 divide steps and 26
// square root steps, scales and hands off the result word.
// Throughput: one vertex per cycle inside an object; the block takes no
// vertex after an object's last vertex until its result word is loaded,
// which waits while the previous result word is still unaccepted. Reset
// clears sums, corners, count, scale_reg (to 1.0) and all handshakes.
// ----------------------------------------------------------------------------
// object_centroid_and_extent
// Centroid and scaled bounding-box diagonal of vertex-streamed objects.
// ----------------------------------------------------------------------------
module object_centroid_and_extent #(
    parameter int MAX_OBJECT_VERTICES = 65536,
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [oce_pkg::SCALE_BITS-1:0] cfg_wdata,
    oce_stream_if.sink   vertex,
    oce_stream_if.source result
);
    localparam int NB = $clog2(MAX_OBJECT_VERTICES + 1);
    localparam int SB = COORD_BITS + NB;
    localparam int QB = COORD_BITS + 2;

    logic [oce_pkg::SCALE_BITS-1:0] scale_reg;
    oce_pkg::oce_cmd_t    cmd;
    oce_pkg::oce_status_t status;
    logic out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= oce_pkg::SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    oce_ctrl #(.DIV_STEPS(SB), .SQRT_STEPS(QB)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vertex.valid), .in_last(vertex.data.object_end),
        .in_ready(vertex.ready),
        .out_valid(out_valid), .out_ready(result.ready),
        .cmd(cmd), .status(status)
    );

    assign result.valid = out_valid;

    oce_datapath #(.CB(COORD_BITS), .NB(NB), .SB(SB), .QB(QB),
                   .MAXV(MAX_OBJECT_VERTICES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .vx(vertex.data.vertex_x), .vy(vertex.data.vertex_y),
        .vz(vertex.data.vertex_z), .scale(scale_reg),
        .cx(result.data.center_x), .cy(result.data.center_y),
        .cz(result.data.center_z), .size(result.data.extent_size),
        .sat(result.data.size_saturated)
    );

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.sqrt_step) |-> !vertex.ready)
        else $error("vertex taken during computation");
    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && vertex.ready && vertex.data.object_end) |=> cmd.finish_load)
        else $error("finish not started after last vertex");
    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> status.count_zero)
        else $error("count not cleared after result");
`endif
endmodule

### hdl/oce_ctrl.sv
// ----------------------------------------------------------------------------
// oce_ctrl
// Sequencer: accumulate vertices, then run divide, square root and scale.
// ----------------------------------------------------------------------------
module oce_ctrl #(
    parameter int DIV_STEPS  = 41,
    parameter int SQRT_STEPS = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output oce_pkg::oce_cmd_t     cmd,
    input  oce_pkg::oce_status_t  status
);
    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam int CW = $clog2(DIV_STEPS + SQRT_STEPS + 1);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;
    logic          take;

    assign in_ready  = (state_reg == ST_ACC);
    assign out_valid = ov_reg;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACC:
            begin
                cmd.accumulate = take;
                if (take && in_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.finish_load = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SQRT_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.scale_mul = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    cmd.clear       = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    logic unused_status;
    assign unused_status = status.count_zero;
endmodule

### hdl/oce_datapath.sv
// ----------------------------------------------------------------------------
// oce_datapath
// Sums, corners and count; serial per-axis dividers with a shared divisor, square root and scaler.
// ----------------------------------------------------------------------------
module oce_datapath #(
    parameter int CB = 24,
    parameter int NB = 17,
    parameter int SB = 41,
    parameter int QB = 26,
    parameter int MAXV = 65536
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  oce_pkg::oce_cmd_t       cmd,
    output oce_pkg::oce_status_t    status,
    input  logic signed [CB-1:0]    vx,
    input  logic signed [CB-1:0]    vy,
    input  logic signed [CB-1:0]    vz,
    input  logic [oce_pkg::SCALE_BITS-1:0] scale,
    output logic signed [CB-1:0]    cx,
    output logic signed [CB-1:0]    cy,
    output logic signed [CB-1:0]    cz,
    output logic [oce_pkg::SIZE_BITS-1:0]  size,
    output logic                    sat
);
    localparam int DB = 2 * CB + 4;       // squared diagonal width
    localparam int MB = 2 * CB + 2;       // one squared axis span
    localparam int PB = QB + oce_pkg::SCALE_BITS;

    logic signed [SB-1:0] sum_reg [3];
    logic signed [CB-1:0] lo_reg [3];
    logic signed [CB-1:0] hi_reg [3];
    logic [NB-1:0]        cnt_reg;
    logic signed [CB-1:0] v [3];

    // divider
    logic [SB-1:0]  dvd_reg [3];
    logic [SB-1:0]  rem_reg [3];
    logic           neg_reg [3];
    logic [NB-1:0]  dvs_reg;
    // square root
    logic [DB-1:0]  sq_reg;
    logic [DB-1:0]  srem_reg;
    logic [QB-1:0]  root_reg;
    logic [PB-1:0]  prod_reg;
    logic [CB:0]    d [3];
    logic [MB-1:0]  dsq_part [3];
    logic [DB-1:0]  dsq;

    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;
    assign status.count_zero = (cnt_reg == '0);

    always_comb
    begin
        dsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            // span needs one bit more than a coordinate
            d[i] = (hi_reg[i] > lo_reg[i])
                 ? ({hi_reg[i][CB-1], hi_reg[i]} - {lo_reg[i][CB-1], lo_reg[i]}) : '0;
            dsq_part[i] = MB'(d[i]) * MB'(d[i]);
            dsq  = dsq + DB'(dsq_part[i]);
        end
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                lo_reg[i]  <= {1'b0, {(CB-1){1'b1}}};
                hi_reg[i]  <= {1'b1, {(CB-1){1'b0}}};
            end
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                lo_reg[i]  <= {1'b0, {(CB-1){1'b1}}};
                hi_reg[i]  <= {1'b1, {(CB-1){1'b0}}};
            end
        end
        else if (cmd.accumulate && (cnt_reg < NB'(MAXV)))
        begin
            cnt_reg <= cnt_reg + 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_reg[i] + SB'(v[i]);
                if (v[i] < lo_reg[i]) lo_reg[i] <= v[i];
                if (v[i] > hi_reg[i]) hi_reg[i] <= v[i];
            end
        end
    end

    // serial divide, square root and scale
    always_ff @(posedge clk)
    begin
        if (cmd.finish_load)
        begin
            dvs_reg <= cnt_reg;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= sum_reg[i][SB-1];
                dvd_reg[i] <= sum_reg[i][SB-1] ? SB'(-sum_reg[i]) : sum_reg[i];
                rem_reg[i] <= '0;
            end
            sq_reg   <= (cnt_reg == '0) ? '0 : dsq;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [SB:0] trial;
                trial = {rem_reg[i], dvd_reg[i][SB-1]} - (SB+1)'(dvs_reg);
                if (!trial[SB])
                begin
                    rem_reg[i] <= trial[SB-1:0];
                    dvd_reg[i] <= {dvd_reg[i][SB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= {rem_reg[i][SB-2:0], dvd_reg[i][SB-1]};
                    dvd_reg[i] <= {dvd_reg[i][SB-2:0], 1'b0};
                end
            end
        end
        if (cmd.sqrt_step)
        begin
            // one result bit per step, two radicand bits shifted in
            logic [DB+1:0] srem2;
            logic [DB+1:0] strial;
            srem2  = {srem_reg, sq_reg[DB-1:DB-2]};
            strial = srem2 - (DB+2)'({root_reg, 2'b01});
            sq_reg <= {sq_reg[DB-3:0], 2'b00};
            if (!strial[DB+1])
            begin
                srem_reg <= strial[DB-1:0];
                root_reg <= {root_reg[QB-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem2[DB-1:0];
                root_reg <= {root_reg[QB-2:0], 1'b0};
            end
        end
        if (cmd.scale_mul)
        begin
            prod_reg <= PB'(root_reg) * PB'(scale);
        end
        if (cmd.result_load)
        begin
            cx <= neg_reg[0] ? CB'(-dvd_reg[0]) : CB'(dvd_reg[0]);
            cy <= neg_reg[1] ? CB'(-dvd_reg[1]) : CB'(dvd_reg[1]);
            cz <= neg_reg[2] ? CB'(-dvd_reg[2]) : CB'(dvd_reg[2]);
            if (|prod_reg[PB-1:8+oce_pkg::SIZE_BITS])
            begin
                size <= '1;
                sat  <= 1'b1;
            end
            else
            begin
                size <= prod_reg[8 +: oce_pkg::SIZE_BITS];
                sat  <= 1'b0;
            end
        end
    end
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams vertex objects into object_centroid_and_extent and checks every
// centroid and scaled extent word against an in-bench predictor. The sender
// runs in bursts and the receiver stalls at random. One long receiver
// hold-off and several idle scale changes are included.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COORD_W    = 24;
    localparam int MAX_VERTS  = 65536;
    localparam int DRAIN_WAIT = 100;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic                      object_end;
    } vertex_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]     center_x;
        logic signed [COORD_W-1:0]     center_y;
        logic signed [COORD_W-1:0]     center_z;
        logic [oce_pkg::SIZE_BITS-1:0] extent_size;
        logic                          size_saturated;
    } result_word_t;

    class centroid_scoreboard;
        longint          axis_sum[3];
        longint          low[3];
        longint          high[3];
        int unsigned     seen;
        logic [15:0]     scale;
        result_word_t    pending[$];
        int              errors;
        int              vertices;
        int              objects;

        function new();
            scale = oce_pkg::SCALE_RESET;
            errors = 0;
            vertices = 0;
            objects = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 3; i++)
            begin
                axis_sum[i] = 0;
                low[i] = longint'(COORD_MAX);
                high[i] = longint'(COORD_MIN);
            end
            seen = 0;
        endfunction

        function void note_vertex(vertex_word_t v);
            longint              c[3];
            longint unsigned     sq;
            longint unsigned     d;
            longint unsigned     root;
            longint unsigned     trial;
            longint unsigned     prod;
            result_word_t        r;
            c[0] = longint'(v.vertex_x);
            c[1] = longint'(v.vertex_y);
            c[2] = longint'(v.vertex_z);
            vertices++;
            // drop vertices past the limit, but still honor the end flag
            if (seen < MAX_VERTS)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    axis_sum[i] += c[i];
                    if (c[i] < low[i]) low[i] = c[i];
                    if (c[i] > high[i]) high[i] = c[i];
                end
                seen++;
            end
            if (!v.object_end)
                return;
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = (seen == 0) ? 0 : axis_sum[i] / longint'(seen);
                d = (seen != 0 && high[i] > low[i]) ? longint'(high[i] - low[i]) : 0;
                sq += d * d;
            end
            r.center_x = c[0][COORD_W-1:0];
            r.center_y = c[1][COORD_W-1:0];
            r.center_z = c[2][COORD_W-1:0];
            root = 0;
            for (int b = 26; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sq) root = trial;
            end
            prod = (root * longint'(scale)) >> 8;
            if (prod > 64'hFFFF_FFFF)
            begin
                r.extent_size = '1;
                r.size_saturated = 1'b1;
            end
            else
            begin
                r.extent_size = prod[oce_pkg::SIZE_BITS-1:0];
                r.size_saturated = 1'b0;
            end
            pending.push_back(r);
            objects++;
            restart();
        endfunction

        function void check_result(result_word_t r);
            result_word_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $realtime, r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.center_x !== e.center_x || r.center_y !== e.center_y
                || r.center_z !== e.center_z || r.extent_size !== e.extent_size
                || r.size_saturated !== e.size_saturated)
            begin
                $display("%0t: mismatch exp c=(%0d,%0d,%0d) size=%0d sat=%0b", $realtime,
                         e.center_x, e.center_y, e.center_z, e.extent_size, e.size_saturated);
                $display("%0t:          act c=(%0d,%0d,%0d) size=%0d sat=%0b", $realtime,
                         r.center_x, r.center_y, r.center_z, r.extent_size, r.size_saturated);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [oce_pkg::SCALE_BITS-1:0] cfg_wdata = '0;

    oce_stream_if #(.payload_t(vertex_word_t)) vertex_ch();
    oce_stream_if #(.payload_t(result_word_t)) result_ch();

    centroid_scoreboard sb = new();

    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_mode = 0;

    initial
    begin
        vertex_ch.valid = 1'b0;
        vertex_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    always #1 clk = ~clk;

    object_centroid_and_extent i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vertex    (vertex_ch),
        .result    (result_ch)
    );

    // note accepted words on both channels
    always @(posedge clk)
    begin
        if (vertex_ch.valid && vertex_ch.ready)
            sb.note_vertex(vertex_ch.data);
        if (result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
    end

    // receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                default: result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready)
            || !rst_n)
            idle_cycles <= 0;
        else if (sb.pending.size() != 0 || vertex_ch.valid)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic send_vertex(vertex_word_t v, bit bursty);
        int gap;
        vertex_ch.valid <= 1'b1;
        vertex_ch.data <= v;
        do
            @(posedge clk);
        while (!vertex_ch.ready);
        if (!bursty)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = $urandom_range(1, 6);
            vertex_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        vertex_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_scale(logic [oce_pkg::SCALE_BITS-1:0] s);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.scale = s;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return '1;
            4: return COORD_W'($signed($urandom_range(0, 2047)) - 1024);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    task automatic send_object(int len);
        vertex_word_t v;
        for (int k = 0; k < len; k++)
        begin
            v.vertex_x = pick_coord();
            v.vertex_y = pick_coord();
            v.vertex_z = pick_coord();
            v.object_end = (k == len - 1) || ($urandom_range(0, 40) == 0);
            send_vertex(v, 1'b1);
        end
    endtask

    task automatic send_fixed(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, bit last);
        send_vertex('{vertex_x: x, vertex_y: y, vertex_z: z, object_end: last}, 1'b0);
    endtask

    initial
    begin
        logic [oce_pkg::SCALE_BITS-1:0] scales[5];
        scales = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd384};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-vertex objects at the coordinate extremes
        send_fixed(COORD_MAX, COORD_MIN, '0, 1'b1);
        send_fixed(COORD_MIN, COORD_MAX, '1, 1'b1);
        // widest possible box, opposite corners
        send_fixed(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_fixed(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // negative sums truncate toward zero
        send_fixed(-24'sd1, -24'sd2, 24'sd5, 1'b0);
        send_fixed(-24'sd1, -24'sd2, 24'sd0, 1'b0);
        send_fixed(24'sd0, -24'sd2, 24'sd0, 1'b1);
        send_fixed(24'sd3, 24'sd4, 24'sd0, 1'b0);
        send_fixed(24'sd0, 24'sd0, 24'sd0, 1'b1);
        vertex_ch.valid <= 1'b0;

        // size saturation at full scale
        write_scale(16'd65535);
        send_fixed(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_fixed(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_fixed(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_fixed(24'sd2000, 24'sd0, 24'sd0, 1'b1);
        write_scale(16'd0);
        send_fixed(COORD_MIN, 24'sd7, COORD_MAX, 1'b0);
        send_fixed(COORD_MAX, 24'sd9, COORD_MIN, 1'b1);

        // random objects under several scales
        for (int phase = 0; phase < 6; phase++)
        begin
            write_scale(phase < 5 ? scales[phase] : oce_pkg::SCALE_BITS'($urandom()));
            if (phase == 2)
                hold_req = 1'b1;
            for (int n = 0; n < 43; n++)
            begin
                send_object($urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6));
                if (n == 21)
                    drain();
            end
        end

        drain();
        $display("testbench: %0d vertices, %0d objects checked over several scales",
                 sb.vertices, sb.objects);
        $display("testbench: directed extremes, saturation and receiver stalls covered");
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### object_centroid_and_extent.f
hdl/oce_pkg.sv
hdl/oce_stream_if.sv
hdl/oce_ctrl.sv
hdl/oce_datapath.sv
hdl/object_centroid_and_extent.sv
tb/testbench.sv
